// ===== rtl/spq_pkg.sv =====
// ============================================================================
// spq_pkg
// Shared types and constants for the stable minimum priority queue.
// ============================================================================
package spq_pkg;

  // Default sizes of the queue and of its entry fields.
  localparam int DEPTH_DEF         = 16;
  localparam int PRIORITY_BITS_DEF = 8;
  localparam int PAYLOAD_BITS_DEF  = 32;

  // Fixed widths of the result fields.
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

endpackage

// ===== rtl/spq_if.sv =====
// ============================================================================
// spq_if
// Request and response channels of the priority queue, valid/ready handshake.
// ============================================================================

// Request channel: one queue operation per transfer.
interface spq_req_if #(
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = spq_pkg::PAYLOAD_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [PRIORITY_BITS-1:0] priority_req;
  logic [PAYLOAD_BITS-1:0]  payload;

  modport source (output valid, output operation, output priority_req, output payload,
                  input ready);
  modport sink   (input valid, input operation, input priority_req, input payload,
                  output ready);
endinterface

// Response channel: one result per operation.
interface spq_rsp_if #(
  parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::STATUS_W-1:0]  status;
  logic [PAYLOAD_BITS-1:0]       removed_payload;
  logic [spq_pkg::COUNT_W-1:0]   entry_count;

  modport source (output valid, output status, output removed_payload, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input removed_payload, input entry_count,
                  output ready);
endinterface

// ===== rtl/spq_ram.sv =====
// ============================================================================
// spq_ram
// Entry store: one write port and one read port with registered read data.
// ============================================================================
module spq_ram #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF,
  parameter int WIDTH = spq_pkg::PRIORITY_BITS_DEF + spq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data is valid the cycle after the request.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/stable_min_priority_queue_top.sv =====
// ============================================================================
// stable_min_priority_queue_top
// Bounded priority queue, sorted by ascending priority number, FIFO on ties.
// ============================================================================
// Usage: each request transfer on req carries an operation (insert or remove
// head), a priority number and a payload. Every request gives exactly one
// response transfer on rsp: a status, the removed payload (zero unless a
// remove succeeds) and the entry count after the operation.
// The entries sit in a circular buffer in one RAM; a remove only advances the
// head pointer, while an insert walks from the tail toward the head, moving
// one entry per cycle up by one place until it finds the slot for the new one.
// Timing: a remove passes the pop state; an insert into a queue neither empty
// nor full walks the scan state (and the place state at the head), as the
// single RAM port pair forces. Every operation then passes the result state,
// which loads the response register. req.ready is high only while the block
// is idle, so one operation is in work at a time.
// Reset (synchronous, active high) empties the queue; RAM contents are not
// cleared. The response sits in an output register; while the receiver
// stalls, the block finishes its work and then waits before taking the next
// request.
// ============================================================================
module stable_min_priority_queue_top #(
  parameter int DEPTH         = spq_pkg::DEPTH_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = spq_pkg::PAYLOAD_BITS_DEF
) (
  input logic clk,
  input logic rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ENT_W = PRIORITY_BITS + PAYLOAD_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_POP,
    S_RESULT
  } state_t;

  state_t                   state;
  logic [IDX_W-1:0]         head;
  logic [CNT_W-1:0]         count;
  logic [IDX_W-1:0]         idx;
  logic [PRIORITY_BITS-1:0] op_pri;
  logic [PAYLOAD_BITS-1:0]  op_pay;
  spq_pkg::status_t         res_status;
  logic [PAYLOAD_BITS-1:0]  res_pay;
  logic                     rsp_vld;
  spq_pkg::status_t         rsp_status;
  logic [PAYLOAD_BITS-1:0]  rsp_pay;
  logic [spq_pkg::COUNT_W-1:0] rsp_count;

  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic [ENT_W-1:0]         wr_data;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic [ENT_W-1:0]         rd_data;
  logic [PRIORITY_BITS-1:0] rd_pri;
  logic [PAYLOAD_BITS-1:0]  rd_pay;
  logic                     shift_up;

  // Map a logical position (offset from the head) onto a RAM address.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  spq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_pri   = rd_data[ENT_W-1 -: PRIORITY_BITS];
  assign rd_pay   = rd_data[PAYLOAD_BITS-1:0];
  // The shared comparator: the stored entry moves up when its number is higher.
  assign shift_up = rd_pri > op_pri;

  // RAM port control for each sequencer step.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = head;
    wr_data = {op_pri, op_pay};
    rd_en   = 1'b0;
    rd_addr = head;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.operation == spq_pkg::OP_INSERT) begin
            if (count == '0) begin
              wr_en   = 1'b1;
              wr_data = {req.priority_req, req.payload};
            end else if (count != CNT_W'(DEPTH)) begin
              rd_en   = 1'b1;
              rd_addr = phys(head, IDX_W'(count - 1'b1));
            end
          end else begin
            rd_en = (count != '0);
          end
        end
      end
      S_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = phys(head, idx + 1'b1);
        if (shift_up) begin
          wr_data = rd_data;
          if (idx != '0) begin
            rd_en   = 1'b1;
            rd_addr = phys(head, idx - 1'b1);
          end
        end
      end
      S_PLACE: begin
        wr_en = 1'b1;
      end
      S_POP, S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer, queue pointers and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      count   <= '0;
      rsp_vld <= 1'b0;
    end else begin
      // Drop the response once it transfers, unless a new one replaces it.
      if (rsp_vld && rsp.ready && state != S_RESULT) begin
        rsp_vld <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_pri     <= req.priority_req;
            op_pay     <= req.payload;
            res_status <= spq_pkg::STATUS_OK;
            res_pay    <= '0;
            state      <= S_RESULT;
            if (req.operation == spq_pkg::OP_INSERT) begin
              if (count == CNT_W'(DEPTH)) begin
                res_status <= spq_pkg::STATUS_FULL;
              end else if (count == '0) begin
                count <= CNT_W'(1);
              end else begin
                idx   <= IDX_W'(count - 1'b1);
                state <= S_SCAN;
              end
            end else if (count == '0) begin
              res_status <= spq_pkg::STATUS_EMPTY;
            end else begin
              state <= S_POP;
            end
          end
        end
        S_SCAN: begin
          if (shift_up) begin
            if (idx == '0) begin
              state <= S_PLACE;
            end else begin
              idx <= idx - 1'b1;
            end
          end else begin
            count <= count + 1'b1;
            state <= S_RESULT;
          end
        end
        S_PLACE: begin
          count <= count + 1'b1;
          state <= S_RESULT;
        end
        S_POP: begin
          res_pay <= rd_pay;
          head    <= phys(head, IDX_W'(1));
          count   <= count - 1'b1;
          state   <= S_RESULT;
        end
        S_RESULT: begin
          if (!rsp_vld || rsp.ready) begin
            rsp_vld    <= 1'b1;
            rsp_status <= res_status;
            rsp_pay    <= res_pay;
            rsp_count  <= spq_pkg::COUNT_W'(count);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready           = (state == S_IDLE);
  assign rsp.valid           = rsp_vld;
  assign rsp.status          = rsp_status;
  assign rsp.removed_payload = rsp_pay;
  assign rsp.entry_count     = rsp_count;

`ifndef SYNTH
  // An accepted request leaves the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while previous operation in work");

  // The entry count never exceeds the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // The insertion walk stays inside the stored entries.
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> CNT_W'(idx) < count)
    else $error("insertion walk outside stored entries");

  // A remove on an empty queue reports no payload and no entries.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == spq_pkg::STATUS_EMPTY
      |-> rsp.removed_payload == '0 && rsp.entry_count == '0)
    else $error("empty status with payload or entries");
`endif

endmodule

// ===== sim/tb_stable_min_priority_queue_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_stable_min_priority_queue_top
// Self-checking testbench for the stable minimum priority queue.
// ============================================================================
// A short table of directed requests covers the corners first: a remove on
// an empty queue, the priority and payload extremes, ties at equal priority,
// filling the queue and an insert into a full queue. Several rows carry a
// typed expectation. Random traffic follows and drifts between insert-heavy
// and remove-heavy stretches so that the queue keeps hitting full and empty.
// A behavioral copy of the queue predicts every response; each response
// transfer is compared field by field with the oldest expectation, typed or
// predicted. Both channels idle at random in two mixes, then run at full rate.
// ============================================================================
module tb_stable_min_priority_queue_top;

  localparam int QUEUE_DEPTH    = spq_pkg::DEPTH_DEF;
  localparam int PRI_W          = spq_pkg::PRIORITY_BITS_DEF;
  localparam int PAY_W          = spq_pkg::PAYLOAD_BITS_DEF;
  localparam int ITEMS_PER_PASS = 410;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 30;

  // One response of the queue.
  typedef struct {
    spq_pkg::status_t            status;
    logic [PAY_W-1:0]            removed_payload;
    logic [spq_pkg::COUNT_W-1:0] entry_count;
  } queue_rsp_t;

  // One row of the directed table; typed rows carry their own expectation.
  typedef struct {
    logic              op;
    logic [PRI_W-1:0]  pri;
    logic [PAY_W-1:0]  pay;
    bit                typed;
    queue_rsp_t        rsp;
  } request_row_t;

  logic clk;
  logic rst;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  stable_min_priority_queue_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the sorted queue, head at index 0.
  logic [PRI_W-1:0] held_pri [QUEUE_DEPTH];
  logic [PAY_W-1:0] held_pay [QUEUE_DEPTH];
  int               held_count;

  queue_rsp_t   pending_rsps [$];
  request_row_t directed_rows [$];

  int mismatches;
  int insert_total;
  int remove_total;
  int refused_inserts;
  int empty_removes;
  int src_idle_pct;
  int rcv_idle_pct;

  // Free-running clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one operation to the shadow queue and return its response.
  function automatic queue_rsp_t apply_operation(logic op, logic [PRI_W-1:0] pri,
                                                 logic [PAY_W-1:0] pay);
    queue_rsp_t r;
    int         slot;
    r.status          = spq_pkg::STATUS_OK;
    r.removed_payload = '0;
    if (op == spq_pkg::OP_INSERT) begin
      insert_total++;
      if (held_count == QUEUE_DEPTH) begin
        r.status = spq_pkg::STATUS_FULL;
        refused_inserts++;
      end else begin
        // Equal priorities stay in arrival order: skip past them.
        slot = 0;
        while (slot < held_count && pri >= held_pri[slot]) slot++;
        for (int i = held_count; i > slot; i--) begin
          held_pri[i] = held_pri[i-1];
          held_pay[i] = held_pay[i-1];
        end
        held_pri[slot] = pri;
        held_pay[slot] = pay;
        held_count++;
      end
    end else begin
      remove_total++;
      if (held_count == 0) begin
        r.status = spq_pkg::STATUS_EMPTY;
        empty_removes++;
      end else begin
        r.removed_payload = held_pay[0];
        for (int i = 0; i + 1 < held_count; i++) begin
          held_pri[i] = held_pri[i+1];
          held_pay[i] = held_pay[i+1];
        end
        held_count--;
      end
    end
    r.entry_count = held_count[spq_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic add_row(logic op, logic [PRI_W-1:0] pri, logic [PAY_W-1:0] pay, bit typed,
                         spq_pkg::status_t st, logic [PAY_W-1:0] rem,
                         logic [spq_pkg::COUNT_W-1:0] cnt);
    request_row_t row;
    row.op                  = op;
    row.pri                 = pri;
    row.pay                 = pay;
    row.typed               = typed;
    row.rsp.status          = st;
    row.rsp.removed_payload = rem;
    row.rsp.entry_count     = cnt;
    directed_rows.push_back(row);
  endtask

  // Drive one request until it transfers, record its expected response, and
  // possibly leave a gap afterwards.
  task automatic issue_request(logic op, logic [PRI_W-1:0] pri, logic [PAY_W-1:0] pay,
                               bit typed, queue_rsp_t typed_rsp);
    queue_rsp_t predicted;
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.priority_req <= pri;
    req_ch.payload      <= pay;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_operation(op, pri, pay);
    pending_rsps.push_back(typed ? typed_rsp : predicted);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every outstanding response has arrived.
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_rsps.size() != 0);
  endtask

  // Receiver: random back-pressure on the response channel.
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Response checker.
  always @(posedge clk) begin
    queue_rsp_t expd;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsps.size() == 0) begin
        $display("%0t: response with nothing expected: status %0d payload %h count %0d",
                 $time, rsp_ch.status, rsp_ch.removed_payload, rsp_ch.entry_count);
        mismatches++;
      end else begin
        expd = pending_rsps.pop_front();
        if (rsp_ch.status !== expd.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, expd.status, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.removed_payload !== expd.removed_payload) begin
          $display("%0t: removed_payload mismatch: expected %h, actual %h",
                   $time, expd.removed_payload, rsp_ch.removed_payload);
          mismatches++;
        end
        if (rsp_ch.entry_count !== expd.entry_count) begin
          $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                   $time, expd.entry_count, rsp_ch.entry_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too many cycles without any transfer ends the run.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: timeout, %0d responses still expected", $time, pending_rsps.size());
    $display("tb_stable_min_priority_queue_top NOT OK");
    $finish;
  end

  // Main stimulus.
  initial begin : stimulus
    queue_rsp_t  no_rsp;
    logic        op;
    logic [PRI_W-1:0] pri;
    int          insert_pct;
    int          pick;
    logic [PRI_W-1:0] fill_pri [16];

    fill_pri = '{8'd3, 8'd3, 8'd200, 8'd0, 8'd3, 8'd255, 8'd1, 8'd0,
                 8'd3, 8'd128, 8'd7, 8'd7, 8'd0, 8'd255, 8'd64, 8'd3};
    no_rsp.status          = spq_pkg::STATUS_OK;
    no_rsp.removed_payload = '0;
    no_rsp.entry_count     = '0;
    mismatches      = 0;
    insert_total    = 0;
    remove_total    = 0;
    refused_inserts = 0;
    empty_removes   = 0;
    held_count      = 0;
    src_idle_pct    = 25;
    rcv_idle_pct    = 48;

    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.operation    <= spq_pkg::OP_INSERT;
    req_ch.priority_req <= '0;
    req_ch.payload      <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table: empty remove, extremes, ties, then fill to overflow.
    add_row(spq_pkg::OP_REMOVE, 8'hA5, 32'hDEADBEEF, 1'b1, spq_pkg::STATUS_EMPTY,
            32'h0, 5'd0);
    add_row(spq_pkg::OP_INSERT, 8'd255, 32'hFFFFFFFF, 1'b1, spq_pkg::STATUS_OK,
            32'h0, 5'd1);
    add_row(spq_pkg::OP_INSERT, 8'd0, 32'hAAAA5555, 1'b1, spq_pkg::STATUS_OK,
            32'h0, 5'd2);
    add_row(spq_pkg::OP_INSERT, 8'd0, 32'h5555AAAA, 1'b1, spq_pkg::STATUS_OK,
            32'h0, 5'd3);
    add_row(spq_pkg::OP_REMOVE, 8'hFF, 32'hFFFFFFFF, 1'b1, spq_pkg::STATUS_OK,
            32'hAAAA5555, 5'd2);
    add_row(spq_pkg::OP_REMOVE, 8'h00, 32'h00000000, 1'b1, spq_pkg::STATUS_OK,
            32'h5555AAAA, 5'd1);
    add_row(spq_pkg::OP_REMOVE, 8'h5A, 32'h12345678, 1'b1, spq_pkg::STATUS_OK,
            32'hFFFFFFFF, 5'd0);
    add_row(spq_pkg::OP_REMOVE, 8'h00, 32'h00000000, 1'b1, spq_pkg::STATUS_EMPTY,
            32'h0, 5'd0);
    for (int i = 0; i < 16; i++)
      add_row(spq_pkg::OP_INSERT, fill_pri[i], 32'h1000_0000 + PAY_W'(i), 1'b0,
              spq_pkg::STATUS_OK, 32'h0, 5'd0);
    add_row(spq_pkg::OP_INSERT, 8'd0, 32'hFFFFFFFF, 1'b1, spq_pkg::STATUS_FULL,
            32'h0, 5'd16);

    foreach (directed_rows[i])
      issue_request(directed_rows[i].op, directed_rows[i].pri, directed_rows[i].pay,
                    directed_rows[i].typed, directed_rows[i].rsp);

    // Random traffic in three idling mixes; the sender drains between them.
    for (int pass = 0; pass < 3; pass++) begin
      drain_responses();
      src_idle_pct = (pass == 0) ? 25 : (pass == 1) ? 48 : 0;
      rcv_idle_pct = (pass == 0) ? 48 : (pass == 1) ? 25 : 0;
      insert_pct   = 50;
      for (int k = 0; k < ITEMS_PER_PASS; k++) begin
        // Change the insert bias now and then so the queue swings end to end.
        if (k % 40 == 0) begin
          pick       = $urandom_range(0, 2);
          insert_pct = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
        end
        op   = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::OP_INSERT
                                                    : spq_pkg::OP_REMOVE;
        pick = $urandom_range(0, 9);
        if (pick < 6)
          pri = PRI_W'($urandom_range(0, 7));
        else if (pick < 8)
          pri = PRI_W'($urandom_range(0, 255));
        else if (pick == 8)
          pri = '0;
        else
          pri = '1;
        issue_request(op, pri, PAY_W'($urandom), 1'b0, no_rsp);
      end
    end

    // Let the last responses and any trailing work finish.
    drain_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d inserts (%0d refused on a full queue) and %0d removes",
             insert_total, refused_inserts, remove_total);
    $display("(%0d on an empty queue), with random and no idling on both channels.",
             empty_removes);
    if (mismatches == 0 && pending_rsps.size() == 0) begin
      $display("tb_stable_min_priority_queue_top OK");
    end else begin
      $display("tb_stable_min_priority_queue_top NOT OK");
    end
    $finish;
  end

endmodule
